@@ rtl/core/wdtmc_pkg.sv @@
// ----------------------------------------------------------------------------
// wdtmc_pkg: shared types and constants for the magic-close watchdog
// Request codes, status codes, field widths and the per-request result.
// ----------------------------------------------------------------------------
package wdtmc_pkg;

	localparam int unsigned TICKS_PER_SECOND_DEF = 100;
	localparam int unsigned MAX_TIMEOUT_DEF      = 3600;

	localparam int unsigned FUNC_W    = 4;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned REQ_W     = 32;
	localparam int unsigned TIMEOUT_W = 12;
	localparam int unsigned COUNT_W   = 19;
	localparam int unsigned STATUS_W  = 2;

	localparam logic [TIMEOUT_W-1:0] DEFAULT_TIMEOUT  = TIMEOUT_W'(60);
	localparam logic [BYTE_W-1:0]    MAGIC_CLOSE_BYTE = 8'h56;
	localparam logic [COUNT_W-1:0]   COUNT_MAX        = {COUNT_W{1'b1}};

	typedef enum logic [FUNC_W-1:0] {
		FUNC_TICK      = 4'd0,
		FUNC_OPEN      = 4'd1,
		FUNC_CLOSE     = 4'd2,
		FUNC_WRITE     = 4'd3,
		FUNC_SET_TMO   = 4'd4,
		FUNC_GET_TMO   = 4'd5,
		FUNC_KEEPALIVE = 4'd6,
		FUNC_GET_LEFT  = 4'd7,
		FUNC_READ_LEFT = 4'd8,
		FUNC_OTHER     = 4'd9
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 2'd0,
		ST_INVAL       = 2'd1,
		ST_UNSUPPORTED = 2'd2
	} status_t;

	typedef struct packed {
		logic                 reboot;
		logic                 value_valid;
		logic [TIMEOUT_W-1:0] value;
		status_t              status;
	} result_t;

endpackage

@@ rtl/core/watchdog_timer_magic_close.sv @@
// ----------------------------------------------------------------------------
// watchdog_timer_magic_close: software watchdog with magic close
// Streaming front end around the watchdog state; one result per request.
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive on the s_ group, results leave on the m_ group; a request
//   or result moves on a rising edge with tvalid and tready both high.
//   s_tuser carries the request code (tick, open, close, write byte, set
//   timeout, get timeout, keepalive, get left, read left, other); s_tdata
//   carries the written byte and the requested timeout.
//   Every request gives exactly one result: status, value, value_valid and
//   the latched reboot flag.
//   A taken request goes into the input register; decode and state update
//   run from the input register into the result register.
//   Throughput: one request per cycle while the receiver takes results;
//   ticks and register requests may arrive back to back.
//   Reset (arst_n low) stops the watchdog, disarms close, restores the
//   default timeout, clears the count and the reboot flag.
//   When the receiver stalls, the result holds in the output register, the
//   next request waits in the input register, and s_tready drops only once
//   both are full.
// ----------------------------------------------------------------------------
module watchdog_timer_magic_close #(
	parameter int unsigned TICKS_PER_SECOND = wdtmc_pkg::TICKS_PER_SECOND_DEF,
	parameter int unsigned MAX_TIMEOUT      = wdtmc_pkg::MAX_TIMEOUT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [7:0] data_byte, [39:8] new_timeout
	input  logic [3:0]  s_tuser,  // [3:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [1:0] status, [13:2] value, [14] value_valid,
	                              // [15] reboot
);
	import wdtmc_pkg::*;

	// input register
	logic              s1_valid;
	func_t             s1_func;
	logic [BYTE_W-1:0] s1_byte;
	logic [REQ_W-1:0]  s1_timeout;

	// result register
	logic              m_valid_q;
	logic [15:0]       m_data_q;

	result_t           res;
	logic              advance;

	// the stage moves on whenever the result register is free or being emptied
	assign advance  = s1_valid && (!m_valid_q || m_tready);
	assign s_tready = !s1_valid || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			s1_func    <= func_t'(s_tuser);
			s1_byte    <= s_tdata[7:0];
			s1_timeout <= s_tdata[39:8];
		end
	end

	wdtmc_core #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND),
		.MAX_TIMEOUT     (MAX_TIMEOUT)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.func       (s1_func),
		.data_byte  (s1_byte),
		.new_timeout(s1_timeout),
		.result     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// result packing follows the struct: status lowest, reboot highest
	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

@@ rtl/core/wdtmc_core.sv @@
// ----------------------------------------------------------------------------
// wdtmc_core: watchdog state and request decode
// Holds the watchdog state, answers one request a cycle when enabled.
// ----------------------------------------------------------------------------
module wdtmc_core #(
	parameter int unsigned TICKS_PER_SECOND = wdtmc_pkg::TICKS_PER_SECOND_DEF,
	parameter int unsigned MAX_TIMEOUT      = wdtmc_pkg::MAX_TIMEOUT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  wdtmc_pkg::func_t                    func,
	input  logic [wdtmc_pkg::BYTE_W-1:0]        data_byte,
	input  logic [wdtmc_pkg::REQ_W-1:0]         new_timeout,
	output wdtmc_pkg::result_t                  result
);
	import wdtmc_pkg::*;

	// elapsed ticks kept also as whole seconds plus a sub-second remainder
	localparam int unsigned SUB_W = (TICKS_PER_SECOND > 1) ? $clog2(TICKS_PER_SECOND) : 1;
	localparam int unsigned SEC_MAX = (2 ** COUNT_W - 1) / TICKS_PER_SECOND;
	localparam int unsigned SEC_W = (SEC_MAX > 1) ? $clog2(SEC_MAX + 1) : 1;
	localparam int unsigned LW = (SEC_W + 1 > TIMEOUT_W) ? SEC_W + 1 : TIMEOUT_W;
	localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(TICKS_PER_SECOND - 1);

	logic                 running_q, armed_q, expired_q;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic [COUNT_W-1:0]   elapsed_q;
	logic [SEC_W-1:0]     sec_q;
	logic [SUB_W-1:0]     sub_q;

	logic                 running_d, armed_d, expired_d;
	logic [TIMEOUT_W-1:0] timeout_d;
	logic [COUNT_W-1:0]   elapsed_d;
	logic [SEC_W-1:0]     sec_d;
	logic [SUB_W-1:0]     sub_d;

	logic [LW-1:0]        ceil_sec, tmo_ext;
	logic [TIMEOUT_W-1:0] left;
	status_t              status;
	logic [TIMEOUT_W-1:0] value;
	logic                 valid;

	// seconds left = timeout - ceil(elapsed / tps), floored at zero
	always_comb begin
		ceil_sec = LW'(sec_q) + LW'(sub_q != '0);
		tmo_ext  = LW'(timeout_q);
		if (tmo_ext > ceil_sec) begin
			left = TIMEOUT_W'(tmo_ext - ceil_sec);
		end else begin
			left = '0;
		end
	end

	always_comb begin
		running_d = running_q;
		armed_d   = armed_q;
		expired_d = expired_q;
		timeout_d = timeout_q;
		elapsed_d = elapsed_q;
		sec_d     = sec_q;
		sub_d     = sub_q;
		status    = ST_OK;
		value     = '0;
		valid     = 1'b0;
		if (!expired_q) begin
			unique case (func)
				FUNC_TICK: begin
					if (elapsed_q != COUNT_MAX) begin
						elapsed_d = elapsed_q + 1'b1;
						if (sub_q == SUB_LAST) begin
							sub_d = '0;
							sec_d = sec_q + 1'b1;
						end else begin
							sub_d = sub_q + 1'b1;
						end
					end
					// elapsed > timeout*tps, in seconds-and-remainder form
					if (running_q && ((LW'(sec_d) > tmo_ext) ||
					    ((LW'(sec_d) == tmo_ext) && (sub_d != '0)))) begin
						expired_d = 1'b1;
					end
				end
				FUNC_OPEN: begin
					if (!running_q) begin
						running_d = 1'b1;
						armed_d   = 1'b0;
						elapsed_d = '0;
						sec_d     = '0;
						sub_d     = '0;
					end
				end
				FUNC_CLOSE: begin
					if (running_q && armed_q) begin
						running_d = 1'b0;
					end
				end
				FUNC_WRITE: begin
					running_d = 1'b1;
					if (!running_q) begin
						armed_d = 1'b0;
					end
					if (data_byte == MAGIC_CLOSE_BYTE) begin
						armed_d = 1'b1;
					end
					elapsed_d = '0;
					sec_d     = '0;
					sub_d     = '0;
				end
				FUNC_SET_TMO: begin
					if ((new_timeout == '0) || (new_timeout > REQ_W'(MAX_TIMEOUT)) ||
					    (new_timeout > REQ_W'({TIMEOUT_W{1'b1}}))) begin
						status = ST_INVAL;
					end else begin
						timeout_d = TIMEOUT_W'(new_timeout);
						elapsed_d = '0;
						sec_d     = '0;
						sub_d     = '0;
					end
				end
				FUNC_GET_TMO: begin
					value = timeout_q;
					valid = 1'b1;
				end
				FUNC_KEEPALIVE: begin
					elapsed_d = '0;
					sec_d     = '0;
					sub_d     = '0;
				end
				FUNC_GET_LEFT: begin
					value = left;
					valid = 1'b1;
				end
				FUNC_READ_LEFT: begin
					if (running_q) begin
						value = left;
						valid = 1'b1;
					end
				end
				default: begin
					status = ST_UNSUPPORTED;
				end
			endcase
		end
		if (expired_d) begin
			status = ST_OK;
			value  = '0;
			valid  = 1'b0;
		end
		result.status      = status;
		result.value       = value;
		result.value_valid = valid;
		result.reboot      = expired_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			armed_q   <= 1'b0;
			expired_q <= 1'b0;
			timeout_q <= DEFAULT_TIMEOUT;
			elapsed_q <= '0;
			sec_q     <= '0;
			sub_q     <= '0;
		end else if (en) begin
			running_q <= running_d;
			armed_q   <= armed_d;
			expired_q <= expired_d;
			timeout_q <= timeout_d;
			elapsed_q <= elapsed_d;
			sec_q     <= sec_d;
			sub_q     <= sub_d;
		end
	end

	// expiry is sticky
	a_expired_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		expired_q |=> expired_q)
		else $error("expired flag cleared without reset");

	// remainder never reaches a full second
	a_sub_range: assert property (@(posedge clk) disable iff (!arst_n)
		sub_q <= SUB_LAST)
		else $error("sub-second count out of range");

	// after expiry requests leave the state alone
	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(en && expired_q) |=> ($stable(timeout_q) && $stable(elapsed_q) &&
		$stable(running_q)))
		else $error("state changed after expiry");

	// keepalive clears every form of the count
	a_keepalive: assert property (@(posedge clk) disable iff (!arst_n)
		(en && !expired_q && (func == FUNC_KEEPALIVE)) |=>
		((elapsed_q == '0) && (sec_q == '0) && (sub_q == '0)))
		else $error("keepalive did not clear the count");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the magic-close watchdog
// Requests from a queue are streamed in bursts with random gaps and the
// receiver stalls on a pattern of its own. A local copy of the watchdog
// predicts every answer, and each result is checked field by field in order.
// The run walks the plain requests, magic close, timeout limits, ticks past
// the deadline while stopped and, at the very end, expiry with its reboot latch.
// ----------------------------------------------------------------------------
module tb;
	import wdtmc_pkg::*;

	localparam int unsigned TIMEOUT_FIELD_MAX = (1 << TIMEOUT_W) - 1;
	localparam int unsigned RANDOM_REQS       = 1100;
	localparam int unsigned STOPPED_TICKS     = 150;
	localparam int unsigned MAX_REPORTS       = 10;

	// watchdog state as the predictor keeps it
	typedef struct packed {
		logic                 running;
		logic                 close_armed;
		logic [TIMEOUT_W-1:0] timeout_s;
		logic [COUNT_W-1:0]   elapsed;
		logic                 expired;
	} wd_state_t;

	// one request, plus pacing marks for the driver
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [BYTE_W-1:0] data_byte;
		logic [REQ_W-1:0]  new_timeout;
		logic              drain;        // wait until all answers are back
		logic              back_to_back; // no gap after this request
	} wd_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;  // [7:0] data_byte, [39:8] new_timeout
	logic [3:0]  s_tuser = '0;  // [3:0] func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;       // [1:0] status, [13:2] value, [14] value_valid,
	                            // [15] reboot

	wd_req_t   req_queue[$];    // requests still to be sent
	result_t   answer_queue[$]; // answers owed by the block, oldest first
	wd_state_t plan_st;         // state seen while building the stimulus
	wd_state_t dut_st;          // state following the accepted requests
	wd_req_t   cur_req;         // request on the bus now

	logic drain_next   = 1'b0;
	logic steady_mode  = 1'b0;
	logic allow_expiry = 1'b0;

	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;
	int unsigned run_left   = 0;
	int unsigned stall_left = 0;

	int unsigned n_accepted  = 0;
	int unsigned n_ticks     = 0;
	int unsigned n_results   = 0;
	int unsigned n_errors    = 0;

	watchdog_timer_magic_close DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor: applies one request to a watchdog state, gives the answer.
	function automatic result_t step_watchdog(inout wd_state_t st, input wd_req_t rq);
		result_t     res;
		int unsigned deadline;
		int unsigned left;
		deadline        = int'(st.timeout_s) * TICKS_PER_SECOND_DEF;
		left            = (deadline > int'(st.elapsed)) ?
		                  (deadline - int'(st.elapsed)) / TICKS_PER_SECOND_DEF : 0;
		res.status      = ST_OK;
		res.value       = '0;
		res.value_valid = 1'b0;
		if (!st.expired) begin
			case (rq.func)
				FUNC_TICK: begin
					// count saturates, and only a running watchdog can expire
					if (st.elapsed != COUNT_MAX)
						st.elapsed++;
					if (st.running && int'(st.elapsed) > deadline)
						st.expired = 1'b1;
				end
				FUNC_OPEN: begin
					if (!st.running) begin
						st.running     = 1'b1;
						st.close_armed = 1'b0;
						st.elapsed     = '0;
					end
				end
				FUNC_CLOSE: begin
					if (st.running && st.close_armed)
						st.running = 1'b0;
				end
				FUNC_WRITE: begin
					if (!st.running) begin
						st.running     = 1'b1;
						st.close_armed = 1'b0;
					end
					st.elapsed = '0;
					if (rq.data_byte == MAGIC_CLOSE_BYTE)
						st.close_armed = 1'b1;
				end
				FUNC_SET_TMO: begin
					if (rq.new_timeout == 0 || rq.new_timeout > MAX_TIMEOUT_DEF ||
					    rq.new_timeout > TIMEOUT_FIELD_MAX) begin
						res.status = ST_INVAL;
					end else begin
						st.timeout_s = rq.new_timeout[TIMEOUT_W-1:0];
						st.elapsed   = '0;
					end
				end
				FUNC_GET_TMO: begin
					res.value       = st.timeout_s;
					res.value_valid = 1'b1;
				end
				FUNC_KEEPALIVE: st.elapsed = '0;
				FUNC_GET_LEFT: begin
					// answers from the count even when stopped
					res.value       = left[TIMEOUT_W-1:0];
					res.value_valid = 1'b1;
				end
				FUNC_READ_LEFT: begin
					if (st.running) begin
						res.value       = left[TIMEOUT_W-1:0];
						res.value_valid = 1'b1;
					end
				end
				default: res.status = ST_UNSUPPORTED;
			endcase
		end
		// expired: everything ignored, answer forced to the reboot form
		if (st.expired) begin
			res.status      = ST_OK;
			res.value       = '0;
			res.value_valid = 1'b0;
		end
		res.reboot = st.expired;
		return res;
	endfunction

	// Queue a request. Unless expiry is wanted, a tick that would expire the
	// watchdog is swapped for a keepalive so the run stays alive.
	task automatic add_request(input logic [3:0] f, input logic [7:0] b,
	                           input logic [31:0] t);
		wd_req_t   rq;
		wd_state_t probe;
		rq.func         = f;
		rq.data_byte    = b;
		rq.new_timeout  = t;
		rq.drain        = drain_next;
		rq.back_to_back = steady_mode;
		if (f == FUNC_TICK && !allow_expiry) begin
			probe = plan_st;
			void'(step_watchdog(probe, rq));
			if (probe.expired)
				rq.func = FUNC_KEEPALIVE;
		end
		void'(step_watchdog(plan_st, rq));
		req_queue.push_back(rq);
		drain_next = 1'b0;
	endtask

	function automatic logic [7:0] rnd_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// Timeout word for set timeout: mostly short (so ticks matter), some full
	// range, some just outside the limits, some raw 32-bit noise.
	function automatic logic [31:0] rnd_timeout();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(1, 4);
			4, 5:       return $urandom_range(1, MAX_TIMEOUT_DEF);
			6:          return $urandom_range(MAX_TIMEOUT_DEF + 1, TIMEOUT_FIELD_MAX + 2);
			7:          return 32'd0;
			default:    return $urandom;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Driver: bursts of requests with random gaps; holds a request until
	// it is taken, and a drain-marked request waits for all answers.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		logic    next_valid;
		wd_req_t rq;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			next_valid = s_tvalid;
			if (s_tvalid && s_tready) begin
				answer_queue.push_back(step_watchdog(dut_st, cur_req));
				n_accepted++;
				if (cur_req.func == FUNC_TICK)
					n_ticks++;
				next_valid = 1'b0;
			end
			if (s_tvalid && !s_tready) begin
				next_valid = 1'b1;
			end else if (gap_left != 0) begin
				gap_left--;
			end else if (req_queue.size() != 0 &&
			             !(req_queue[0].drain && answer_queue.size() != 0)) begin
				rq         = req_queue.pop_front();
				cur_req    = rq;
				next_valid = 1'b1;
				s_tdata   <= {rq.new_timeout, rq.data_byte};
				s_tuser   <= rq.func;
				if (rq.back_to_back) begin
					gap_left = 0;
				end else if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end
			s_tvalid <= next_valid;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each result against the oldest owed answer; the
	// receiver runs ready for a random stretch, then stalls for a while.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		result_t got;
		result_t want;
		logic    next_ready;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata);
				n_results++;
				if (answer_queue.size() == 0) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS)
						$display("ERROR: result %0d with nothing owed: %h", n_results, m_tdata);
				end else begin
					want = answer_queue.pop_front();
					if (got.status !== want.status || got.value !== want.value ||
					    got.value_valid !== want.value_valid ||
					    got.reboot !== want.reboot) begin
						n_errors++;
						if (n_errors <= MAX_REPORTS)
							$display({"ERROR: result %0d expected status %0d value %0d ",
							          "valid %0b reboot %0b, got status %0d value %0d ",
							          "valid %0b reboot %0b"},
							         n_results, want.status, want.value, want.value_valid,
							         want.reboot, got.status, got.value, got.value_valid,
							         got.reboot);
					end
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				next_ready = 1'b0;
			end else if (run_left != 0) begin
				run_left--;
				next_ready = 1'b1;
			end else begin
				run_left   = $urandom_range(1, 32);
				stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 12) :
				             $urandom_range(0, 3);
				next_ready = (stall_left == 0);
			end
			m_tready <= next_ready;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int unsigned n;
		int unsigned random_end;
		plan_st = '{running: 1'b0, close_armed: 1'b0, timeout_s: DEFAULT_TIMEOUT,
		            elapsed: '0, expired: 1'b0};
		dut_st  = plan_st;

		// directed: defaults, stopped behaviour, timeout limits, magic close
		add_request(FUNC_GET_TMO,   rnd_byte(), $urandom);
		add_request(FUNC_READ_LEFT, rnd_byte(), $urandom);
		add_request(FUNC_GET_LEFT,  rnd_byte(), $urandom);
		add_request(FUNC_TICK,      rnd_byte(), $urandom);
		add_request(FUNC_TICK,      rnd_byte(), $urandom);
		add_request(FUNC_CLOSE,     rnd_byte(), $urandom);
		add_request(FUNC_KEEPALIVE, rnd_byte(), $urandom);
		add_request(FUNC_SET_TMO,   rnd_byte(), 32'd0);
		add_request(FUNC_SET_TMO,   rnd_byte(), MAX_TIMEOUT_DEF + 1);
		add_request(FUNC_SET_TMO,   rnd_byte(), TIMEOUT_FIELD_MAX + 1);
		add_request(FUNC_SET_TMO,   rnd_byte(), 32'hFFFF_FFFF);
		add_request(FUNC_SET_TMO,   rnd_byte(), MAX_TIMEOUT_DEF);
		add_request(FUNC_GET_LEFT,  rnd_byte(), $urandom);
		add_request(FUNC_SET_TMO,   rnd_byte(), 32'd1);
		add_request(FUNC_GET_TMO,   rnd_byte(), $urandom);
		add_request(FUNC_OPEN,      rnd_byte(), $urandom);
		add_request(FUNC_OPEN,      rnd_byte(), $urandom);
		add_request(FUNC_READ_LEFT, rnd_byte(), $urandom);
		add_request(FUNC_WRITE,     8'h00,      $urandom);
		add_request(FUNC_WRITE,     8'hFF,      $urandom);
		add_request(FUNC_CLOSE,     rnd_byte(), $urandom); // not armed: keeps running
		add_request(FUNC_WRITE,     MAGIC_CLOSE_BYTE, $urandom);
		add_request(FUNC_CLOSE,     rnd_byte(), $urandom); // armed: stops
		add_request(FUNC_READ_LEFT, rnd_byte(), $urandom);
		add_request(FUNC_OTHER,     rnd_byte(), $urandom);
		add_request(4'hF,           rnd_byte(), $urandom);

		// random part: short well-formed sequences with random content
		drain_next = 1'b1;
		random_end = req_queue.size() + RANDOM_REQS;
		while (req_queue.size() < random_end) begin
			if ($urandom_range(0, 39) == 0)
				drain_next = 1'b1;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					// tick run, with the odd query inside
					if ($urandom_range(0, 1) == 0)
						add_request(FUNC_WRITE, rnd_byte(), $urandom);
					n = $urandom_range(1, 150);
					repeat (n) begin
						if ($urandom_range(0, 9) == 0)
							add_request($urandom_range(0, 1) ? FUNC_GET_LEFT : FUNC_READ_LEFT,
							            rnd_byte(), $urandom);
						else
							add_request(FUNC_TICK, rnd_byte(), $urandom);
					end
					add_request(FUNC_READ_LEFT, rnd_byte(), $urandom);
				end
				4: begin
					add_request(FUNC_SET_TMO, rnd_byte(), rnd_timeout());
					add_request(FUNC_GET_TMO, rnd_byte(), $urandom);
				end
				5: begin
					add_request(FUNC_WRITE, ($urandom_range(0, 2) == 0) ? MAGIC_CLOSE_BYTE :
					            rnd_byte(), $urandom);
					if ($urandom_range(0, 1) == 0)
						add_request(FUNC_CLOSE, rnd_byte(), $urandom);
				end
				6: begin
					// magic close, with some ticks or a plain byte before the close
					add_request(FUNC_WRITE, MAGIC_CLOSE_BYTE, $urandom);
					n = $urandom_range(0, 5);
					repeat (n)
						add_request(FUNC_TICK, rnd_byte(), $urandom);
					if ($urandom_range(0, 3) == 0)
						add_request(FUNC_WRITE, rnd_byte(), $urandom);
					add_request(FUNC_CLOSE, rnd_byte(), $urandom);
					add_request(FUNC_READ_LEFT, rnd_byte(), $urandom);
				end
				7: begin
					n = $urandom_range(1, 4);
					repeat (n)
						case ($urandom_range(0, 2))
							0:       add_request(FUNC_OPEN,      rnd_byte(), $urandom);
							1:       add_request(FUNC_CLOSE,     rnd_byte(), $urandom);
							default: add_request(FUNC_KEEPALIVE, rnd_byte(), $urandom);
						endcase
				end
				8: begin
					add_request(FUNC_GET_TMO,   rnd_byte(), $urandom);
					add_request(FUNC_GET_LEFT,  rnd_byte(), $urandom);
					add_request(FUNC_READ_LEFT, rnd_byte(), $urandom);
				end
				default: begin
					// noise: any code, any fields
					n = $urandom_range(1, 6);
					repeat (n)
						add_request(4'($urandom_range(0, 15)), rnd_byte(), $urandom);
				end
			endcase
		end

		// stopped watchdog, one-second timeout, ticks well past it back to back
		add_request(FUNC_WRITE, MAGIC_CLOSE_BYTE, $urandom);
		add_request(FUNC_CLOSE, rnd_byte(), $urandom);
		add_request(FUNC_SET_TMO, rnd_byte(), 32'd1);
		add_request(FUNC_KEEPALIVE, rnd_byte(), $urandom);
		steady_mode = 1'b1;
		repeat (STOPPED_TICKS)
			add_request(FUNC_TICK, rnd_byte(), $urandom);
		steady_mode = 1'b0;
		add_request(FUNC_GET_LEFT,  rnd_byte(), $urandom);
		add_request(FUNC_READ_LEFT, rnd_byte(), $urandom);
		add_request(FUNC_GET_TMO,   rnd_byte(), $urandom);
		add_request(FUNC_OPEN,      rnd_byte(), $urandom);
		add_request(FUNC_GET_LEFT,  rnd_byte(), $urandom);

		// expiry last of all: one-second timeout, tick past the deadline
		add_request(FUNC_SET_TMO,  rnd_byte(), 32'd1);
		add_request(FUNC_WRITE,    rnd_byte(), $urandom);
		add_request(FUNC_GET_LEFT, rnd_byte(), $urandom);
		repeat (TICKS_PER_SECOND_DEF)
			add_request(FUNC_TICK, rnd_byte(), $urandom);
		add_request(FUNC_GET_LEFT,  rnd_byte(), $urandom);
		add_request(FUNC_READ_LEFT, rnd_byte(), $urandom);
		allow_expiry = 1'b1;
		add_request(FUNC_TICK, rnd_byte(), $urandom);
		repeat (20)
			add_request(4'($urandom_range(0, 15)), rnd_byte(), $urandom);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (req_queue.size() != 0 || s_tvalid)
			@(posedge clk);
		while (answer_queue.size() != 0)
			@(posedge clk);
		// two-stage pipeline: keep the clock running so stray results still show up
		repeat (8) @(posedge clk);

		$display("Run covered %0d requests (%0d ticks), %0d results checked, %0d errors",
		         n_accepted, n_ticks, n_results, n_errors);
		$display("Stopped ticks past the deadline included, reboot latched at the end: %0b",
		         dut_st.expired);
		if (n_errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#400000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/wdtmc_pkg.sv
rtl/core/wdtmc_core.sv
rtl/core/watchdog_timer_magic_close.sv
tb/tb.sv
